// ----- src/gbl_pkg.sv -----
// Shared types and constants of the 3x3 Gaussian blur stream.
`default_nettype none

package gbl_pkg;

  // Q0.16 weights: 0.12 for the centre and its direct neighbours, 0.09 for the diagonals.
  localparam logic [12:0] W_EDGE = 13'd7864;
  localparam logic [12:0] W_DIAG = 13'd5898;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned HEIGHT_MAX = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  blurred;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        last;
  } pix_out_t;

endpackage

`default_nettype wire

// ----- src/gbl_linebuf.sv -----
// Two-row line buffer held in one synchronous memory, with write-to-read forwarding.
`default_nettype none

module gbl_linebuf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_px_i,
  output logic      [7:0]    up1_o,
  output logic      [7:0]    up2_o
);

  // Each word holds the row above in its upper byte and the row two above in its lower byte.
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;
  logic [15:0] fwd_word_q;
  logic        fwd_q;
  logic [15:0] word;

  assign word  = fwd_q ? fwd_word_q : rd_q;
  assign up1_o = word[15:8];
  assign up2_o = word[7:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_px_i, up1_o};
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_word_q <= {wr_px_i, up1_o};
    end
  end

  // A read of the entry being written in the same cycle takes the new word instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

`default_nettype wire

// ----- src/gaussian_blur_3x3_stream.sv -----
// Top level of the 3x3 Gaussian blur over a raster stream of gray pixels.
// A result passes the stage one, two and three registers and then the output queue.
// Throughput: one pixel per clock while in_stall_o is low, set by the single read and
// write of the line buffer per pixel; an eight-entry output queue absorbs result stalls.
// Reset (asynchronous, active low) clears the counters, window, pipeline and queue and
// sets the geometry to 640 x 480; the line-buffer memory is not cleared.
`default_nettype none

module gaussian_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gbl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [gbl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire gbl_pkg::pix_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output gbl_pkg::pix_out_t                     out_data_o
);

  // Column counter addresses the line buffer; the stored width can also hold MAX_WIDTH.
  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RESET_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int unsigned QDEPTH  = 8;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  // Geometry registers, stored clamped to their legal ranges; width uses the low twelve bits.
  logic [WW-1:0] width_q, width_d;
  logic [12:0]   height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (gbl_pkg::cfg_idx_e'(cfg_idx_i))
        gbl_pkg::CFG_IMAGE_WIDTH: begin
          if (cfg_wdata_i[11:0] < 12'd4) begin
            width_d = WW'(4);
          end else if (32'(cfg_wdata_i[11:0]) > MAX_WIDTH) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(cfg_wdata_i[11:0]);
          end
        end
        gbl_pkg::CFG_IMAGE_HEIGHT: begin
          if (cfg_wdata_i < 13'd4) begin
            height_d = 13'd4;
          end else if (32'(cfg_wdata_i) > gbl_pkg::HEIGHT_MAX) begin
            height_d = 13'(gbl_pkg::HEIGHT_MAX);
          end else begin
            height_d = cfg_wdata_i;
          end
        end
      endcase
    end
  end

  // Input side. An item is accepted while the reservation count leaves room in the
  // output queue for every item that may still produce a result.
  logic in_acc;
  logic out_pop;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_pop = out_valid_o && !out_stall_i;

  logic [CW-1:0] col_q, col_d;
  logic [11:0]   row_q, row_d;
  logic [CW-1:0] col;
  logic [11:0]   row;
  logic [WW-1:0] col_inc;
  logic [12:0]   row_inc;
  logic          emit;
  logic          last;

  // A frame start clears the counters before this pixel is placed.
  assign col     = in_data_i.frame_start ? '0 : col_q;
  assign row     = in_data_i.frame_start ? '0 : row_q;
  assign col_inc = WW'(col) + WW'(1);
  assign row_inc = 13'(row) + 13'd1;

  // The pixel at (row, col) completes the window centred on (row-1, col-1). That centre
  // is interior when it is at least two rows and columns in and short of the last ones.
  assign emit = (row >= 12'd3) && (32'(col) >= 3) && (13'(row) < height_q)
              && (WW'(col) < width_q);
  assign last = (13'(row) == height_q - 13'd1) && (WW'(col) == width_q - WW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_inc >= width_q) begin
        col_d = '0;
        row_d = (row_inc >= height_q) ? 12'd0 : row_inc[11:0];
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = row;
      end
    end
  end

  // Stage one: the line-buffer read is in flight.
  logic          v1_q;
  logic [CW-1:0] col1_q;
  logic [7:0]    px1_q;
  logic          emit1_q, last1_q;
  logic [11:0]   r1_q;
  logic [10:0]   c1_q;
  logic [7:0]    up1, up2;

  gbl_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col),
    .wr_en_i   (v1_q),
    .wr_addr_i (col1_q),
    .wr_px_i   (px1_q),
    .up1_o     (up1),
    .up2_o     (up2)
  );

  // Stage two: the window holds the full neighbourhood and the weighted sums are formed.
  logic [7:0]  win_q [3][3];
  logic        v2_q, emit2_q, last2_q;
  logic [11:0] r2_q;
  logic [10:0] c2_q;

  logic [9:0]  sum_cns;
  logic [8:0]  sum_ew, sum_sd, sum_nd;
  logic [22:0] prod_cns;
  logic [21:0] prod_ew, prod_sd, prod_nd;

  assign sum_cns  = 10'(win_q[1][1]) + 10'(win_q[0][1]) + 10'(win_q[2][1]);
  assign sum_ew   = 9'(win_q[1][2]) + 9'(win_q[1][0]);
  assign sum_sd   = 9'(win_q[2][2]) + 9'(win_q[2][0]);
  assign sum_nd   = 9'(win_q[0][2]) + 9'(win_q[0][0]);
  assign prod_cns = 23'(gbl_pkg::W_EDGE) * 23'(sum_cns);
  assign prod_ew  = 22'(gbl_pkg::W_EDGE) * 22'(sum_ew);
  assign prod_sd  = 22'(gbl_pkg::W_DIAG) * 22'(sum_sd);
  assign prod_nd  = 22'(gbl_pkg::W_DIAG) * 22'(sum_nd);

  // Stage three: each partial product is already truncated to an integer; add them up.
  logic        v3_q, emit3_q, last3_q;
  logic [11:0] r3_q;
  logic [10:0] c3_q;
  logic [7:0]  t_cns_q, t_ew_q, t_sd_q, t_nd_q;
  logic [9:0]  total;
  logic        q_push, q_drop;

  assign total  = 10'(t_cns_q) + 10'(t_ew_q) + 10'(t_sd_q) + 10'(t_nd_q);
  assign q_push = v3_q && emit3_q;
  assign q_drop = v3_q && !emit3_q;

  // Output queue and reservation count (items accepted but not yet taken or dropped).
  gbl_pkg::pix_out_t q_mem [QDEPTH];
  logic [QAW-1:0]    q_wr_q, q_rd_q;
  logic [QCW-1:0]    q_cnt_q, q_cnt_d;
  logic [QCW-1:0]    res_q, res_d;

  always_comb begin
    q_cnt_d = q_cnt_q + QCW'(q_push) - QCW'(out_pop);
    res_d   = res_q + QCW'(in_acc) - QCW'(out_pop) - QCW'(q_drop);
  end

  assign in_stall_o  = (res_q == QCW'(QDEPTH));
  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = q_mem[q_rd_q];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col1_q  <= col;
      px1_q   <= in_data_i.pixel;
      emit1_q <= emit;
      last1_q <= last;
      r1_q    <= row - 12'd1;
      c1_q    <= 11'(col - CW'(1));
    end
    if (v1_q) begin
      emit2_q <= emit1_q;
      last2_q <= last1_q;
      r2_q    <= r1_q;
      c2_q    <= c1_q;
    end
    if (v2_q) begin
      emit3_q <= emit2_q;
      last3_q <= last2_q;
      r3_q    <= r2_q;
      c3_q    <= c2_q;
      t_cns_q <= 8'(prod_cns[22:16]);
      t_ew_q  <= 8'(prod_ew[21:16]);
      t_sd_q  <= 8'(prod_sd[21:16]);
      t_nd_q  <= 8'(prod_nd[21:16]);
    end
    if (q_push) begin
      q_mem[q_wr_q] <= '{blurred: total[7:0], out_row: r3_q, out_col: c3_q, last: last3_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RESET_W);
      height_q <= 13'd480;
      col_q    <= '0;
      row_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      q_wr_q   <= '0;
      q_rd_q   <= '0;
      q_cnt_q  <= '0;
      res_q    <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= 8'd0;
        end
      end
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      v1_q     <= in_acc;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      q_cnt_q  <= q_cnt_d;
      res_q    <= res_d;
      if (q_push) begin
        q_wr_q <= q_wr_q + QAW'(1);
      end
      if (out_pop) begin
        q_rd_q <= q_rd_q + QAW'(1);
      end
      // The window slides left by one column as each pixel's column arrives.
      if (v1_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= up2;
        win_q[1][2] <= up1;
        win_q[2][2] <= px1_q;
      end
    end
  end

`ifndef SYNTH
  a_queue_within_reservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= res_q)
    else $error("output queue holds more items than are reserved");

  a_reservation_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q <= QCW'(QDEPTH))
    else $error("reservation count exceeds queue depth");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !out_pop) |-> (q_cnt_q < QCW'(QDEPTH)))
    else $error("result pushed into a full output queue");

  a_frame_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.frame_start) |=> (v1_q && !emit1_q))
    else $error("first pixel of a frame marked as producing a result");
`endif

endmodule

`default_nettype wire
